### rtl/bbc_pkg.sv
`timescale 1ns / 1ps
// Shared types for the block buffer cache tag store.
// No dependencies.
package bbc_pkg;

  localparam int DEV_W  = 8;
  localparam int BLK_W  = 48;
  localparam int SIZE_W = 17;
  localparam int TAG_W  = DEV_W + BLK_W + SIZE_W;

  typedef enum logic [1:0] {
    CMD_GET        = 2'd0,
    CMD_RELEASE    = 2'd1,
    CMD_MARK_VALID = 2'd2,
    CMD_INVALIDATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_SCAN    = 8'b0000_0100,
    S_DEC     = 8'b0000_1000,
    S_UPD     = 8'b0001_0000,
    S_SLOT_RD = 8'b0010_0000,
    S_SLOT_WR = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

endpackage

### rtl/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// Block buffer cache tag store: LRU replacement with pinned entries.
// Depends on bbc_pkg for command, status and state codes.
//
// Operation: every request reaches the entry memories through one read port.
// A get makes a lookup pass, then a recency update pass unless the store is
// full; an invalidate makes a lookup pass only; release and mark valid read
// and update the one named slot. After reset a clearing pass initializes pin
// counts and ranks; no request is taken until it ends. A new request is taken
// while the previous result still waits on the output register.
module block_buffer_cache_lru
  import bbc_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int PIN_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [DEV_W-1:0]           in_device_id,
  input  logic [BLK_W-1:0]           in_block_number,
  input  logic [SIZE_W-1:0]          in_block_bytes,
  input  logic [$clog2(ENTRIES)-1:0] in_slot_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(ENTRIES)-1:0] out_slot_out,
  output logic                       out_hit,
  output logic                       out_needs_read,
  output logic [1:0]                 out_status
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int R_LSB = 0;
  localparam int P_LSB = IW;
  localparam int V_BIT = IW + PIN_BITS;
  localparam int U_BIT = V_BIT + 1;
  localparam int MW    = U_BIT + 1;
  localparam logic [IW-1:0]       LAST    = IW'(ENTRIES - 1);
  localparam logic [IW:0]         ENT_W   = (IW + 1)'(ENTRIES);
  localparam logic [CW-1:0]       ENT_C   = CW'(ENTRIES);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic [TAG_W-1:0] tag_mem [ENTRIES];
  logic [MW-1:0]    meta_mem [ENTRIES];

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] in_use_r, in_use_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [TAG_W-1:0] tag_q_r;
  logic [MW-1:0] meta_q_r;

  cmd_t cmd_r, cmd_nxt;
  logic [TAG_W-1:0] req_tag_r, req_tag_nxt;
  logic [IW-1:0] slot_r, slot_nxt;

  logic hit_got_r, hit_got_nxt, hit_val_r, hit_val_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt, hit_rank_r, hit_rank_nxt;
  logic free_got_r, free_got_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt, free_rank_r, free_rank_nxt;
  logic vic_got_r, vic_got_nxt;
  logic [IW-1:0] vic_idx_r, vic_idx_nxt, vic_rank_r, vic_rank_nxt;
  logic [IW-1:0] tgt_idx_r, tgt_idx_nxt, tgt_rank_r, tgt_rank_nxt;
  logic fill_r, fill_nxt;

  logic [IW-1:0] res_slot_r, res_slot_nxt;
  logic res_hit_r, res_hit_nxt, res_nr_r, res_nr_nxt;
  status_t res_stat_r, res_stat_nxt;
  logic out_valid_r, out_valid_nxt, load_out;
  logic [IW-1:0] out_slot_r;
  logic out_hit_r, out_nr_r;
  status_t out_stat_r;

  logic [IW-1:0] raddr;
  logic meta_we, tag_we;
  logic [IW-1:0] meta_wa;
  logic [MW-1:0] meta_wd;

  logic m_used, m_valid;
  logic [PIN_BITS-1:0] m_pin;
  logic [IW-1:0] m_rank;

  assign m_used  = meta_q_r[U_BIT];
  assign m_valid = meta_q_r[V_BIT];
  assign m_pin   = meta_q_r[P_LSB +: PIN_BITS];
  assign m_rank  = meta_q_r[R_LSB +: IW];

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_use_nxt    = in_use_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = cnt_r[IW-1:0];
    raddr         = cnt_r[IW-1:0];
    cmd_nxt       = cmd_r;
    req_tag_nxt   = req_tag_r;
    slot_nxt      = slot_r;
    hit_got_nxt   = hit_got_r;
    hit_val_nxt   = hit_val_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    free_got_nxt  = free_got_r;
    free_idx_nxt  = free_idx_r;
    free_rank_nxt = free_rank_r;
    vic_got_nxt   = vic_got_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    tgt_idx_nxt   = tgt_idx_r;
    tgt_rank_nxt  = tgt_rank_r;
    fill_nxt      = fill_r;
    res_slot_nxt  = res_slot_r;
    res_hit_nxt   = res_hit_r;
    res_nr_nxt    = res_nr_r;
    res_stat_nxt  = res_stat_r;
    load_out      = 1'b0;
    meta_we       = 1'b0;
    meta_wa       = rd_idx_r;
    meta_wd       = meta_q_r;
    tag_we        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = cnt_r[IW-1:0];
        meta_wd = '0;
        meta_wd[R_LSB +: IW] = cnt_r[IW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r[IW-1:0] == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = cmd_t'(in_cmd);
          req_tag_nxt  = {in_device_id, in_block_number, in_block_bytes};
          slot_nxt     = in_slot_index;
          hit_got_nxt  = 1'b0;
          free_got_nxt = 1'b0;
          vic_got_nxt  = 1'b0;
          cnt_nxt      = '0;
          res_slot_nxt = in_slot_index;
          res_hit_nxt  = 1'b0;
          res_nr_nxt   = 1'b0;
          res_stat_nxt = STAT_OK;
          if (cmd_t'(in_cmd) == CMD_GET || cmd_t'(in_cmd) == CMD_INVALIDATE) begin
            state_nxt = S_SCAN;
          end else if ({1'b0, in_slot_index} < ENT_W) begin
            state_nxt = S_SLOT_RD;
          end else begin
            if (cmd_t'(in_cmd) == CMD_RELEASE) res_stat_nxt = STAT_UNDERFLOW;
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < ENT_C) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (cmd_r == CMD_GET) begin
            if (m_used && tag_q_r == req_tag_r && !hit_got_r) begin
              hit_got_nxt  = 1'b1;
              hit_idx_nxt  = rd_idx_r;
              hit_rank_nxt = m_rank;
              hit_val_nxt  = m_valid;
            end
            if (!m_used && !free_got_r) begin
              free_got_nxt  = 1'b1;
              free_idx_nxt  = rd_idx_r;
              free_rank_nxt = m_rank;
            end
            if (m_used && m_pin == '0 && (!vic_got_r || m_rank > vic_rank_r)) begin
              vic_got_nxt  = 1'b1;
              vic_idx_nxt  = rd_idx_r;
              vic_rank_nxt = m_rank;
            end
          end else if (m_used && m_pin == '0 &&
                       tag_q_r[TAG_W-1 -: DEV_W] == req_tag_r[TAG_W-1 -: DEV_W]) begin
            meta_we        = 1'b1;
            meta_wd[V_BIT] = 1'b0;
          end
          if (rd_idx_r == LAST) begin
            if (cmd_r == CMD_GET) begin
              state_nxt = S_DEC;
            end else begin
              res_slot_nxt = '0;
              state_nxt    = S_DONE;
            end
          end
        end
      end
      S_DEC: begin
        cnt_nxt   = '0;
        state_nxt = S_UPD;
        res_hit_nxt = 1'b0;
        res_nr_nxt  = 1'b1;
        fill_nxt    = 1'b1;
        priority if (hit_got_r) begin
          tgt_idx_nxt  = hit_idx_r;
          tgt_rank_nxt = hit_rank_r;
          fill_nxt     = 1'b0;
          res_hit_nxt  = 1'b1;
          res_nr_nxt   = !hit_val_r;
        end else if (free_got_r && in_use_r < ENT_C) begin
          tgt_idx_nxt  = free_idx_r;
          tgt_rank_nxt = free_rank_r;
          in_use_nxt   = in_use_r + CW'(1);
          tag_we       = 1'b1;
        end else if (vic_got_r) begin
          tgt_idx_nxt  = vic_idx_r;
          tgt_rank_nxt = vic_rank_r;
          tag_we       = 1'b1;
        end else begin
          res_nr_nxt   = 1'b0;
          res_stat_nxt = STAT_FULL;
          state_nxt    = S_DONE;
        end
        res_slot_nxt = (state_nxt == S_DONE) ? '0 : tgt_idx_nxt;
      end
      S_UPD: begin
        if (cnt_r < ENT_C) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          meta_we = 1'b1;
          if (rd_idx_r == tgt_idx_r) begin
            meta_wd[R_LSB +: IW] = '0;
            if (fill_r) begin
              meta_wd[U_BIT] = 1'b1;
              meta_wd[V_BIT] = 1'b0;
              meta_wd[P_LSB +: PIN_BITS] = PIN_BITS'(1);
            end else if (m_pin != PIN_MAX) begin
              meta_wd[P_LSB +: PIN_BITS] = m_pin + PIN_BITS'(1);
            end
          end else if (m_rank < tgt_rank_r) begin
            meta_wd[R_LSB +: IW] = m_rank + IW'(1);
          end
          if (rd_idx_r == LAST) state_nxt = S_DONE;
        end
      end
      S_SLOT_RD: begin
        raddr     = slot_r;
        state_nxt = S_SLOT_WR;
      end
      S_SLOT_WR: begin
        meta_wa   = slot_r;
        state_nxt = S_DONE;
        if (cmd_r == CMD_RELEASE) begin
          if (m_used && m_pin != '0) begin
            meta_we = 1'b1;
            meta_wd[P_LSB +: PIN_BITS] = m_pin - PIN_BITS'(1);
          end else begin
            res_stat_nxt = STAT_UNDERFLOW;
          end
        end else if (m_used) begin
          meta_we        = 1'b1;
          meta_wd[V_BIT] = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      in_use_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hit_got_r   <= 1'b0;
      free_got_r  <= 1'b0;
      vic_got_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      in_use_r    <= in_use_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      hit_got_r   <= hit_got_nxt;
      free_got_r  <= free_got_nxt;
      vic_got_r   <= vic_got_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cmd_r       <= cmd_nxt;
    req_tag_r   <= req_tag_nxt;
    slot_r      <= slot_nxt;
    hit_val_r   <= hit_val_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    free_idx_r  <= free_idx_nxt;
    free_rank_r <= free_rank_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    tgt_idx_r   <= tgt_idx_nxt;
    tgt_rank_r  <= tgt_rank_nxt;
    fill_r      <= fill_nxt;
    res_slot_r  <= res_slot_nxt;
    res_hit_r   <= res_hit_nxt;
    res_nr_r    <= res_nr_nxt;
    res_stat_r  <= res_stat_nxt;
    if (load_out) begin
      out_slot_r <= res_slot_r;
      out_hit_r  <= res_hit_r;
      out_nr_r   <= res_nr_r;
      out_stat_r <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tgt_idx_nxt] <= req_tag_r;
    tag_q_r <= tag_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_q_r <= meta_mem[raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_slot_out   = out_slot_r;
  assign out_hit        = out_hit_r;
  assign out_needs_read = out_nr_r;
  assign out_status     = out_stat_r;

  a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= ENT_C)
    else $error("entry count exceeds store size");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit || out_needs_read) |-> out_status == STAT_OK)
    else $error("hit or read request with error status");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE && state_r != S_CLEAR)
    else $error("accepted request left no work");

  a_upd_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD && rd_vld_r |-> meta_we)
    else $error("update pass skipped an entry");

endmodule
